// ----- rtl/core/bu2x_pkg.sv -----
// Shared constants, job type and tap helper for the 2x bilinear upsampler.
`timescale 1ns / 1ps
`default_nettype none

package bu2x_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS   = 11;
  localparam int POS_BITS    = 11;
  localparam int TOP_BITS    = SAMPLE_BITS + 3;
  localparam int SUM_BITS    = SAMPLE_BITS + 6;

  localparam logic CFG_IN_WIDTH  = 1'b0;
  localparam logic CFG_IN_HEIGHT = 1'b1;

  // Everything one input sample needs to produce its output pixels.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] cur;
    logic signed [SAMPLE_BITS-1:0] above;
    logic signed [SAMPLE_BITS-1:0] above_left;
    logic signed [SAMPLE_BITS-1:0] left;
    logic [ROW_BITS-1:0]           row;
    logic [COL_BITS-1:0]           col;
    logic                          row_first;
    logic                          row_last;
    logic                          col_first;
    logic                          col_last;
    logic [POS_BITS-1:0]           row_end;
    logic [POS_BITS-1:0]           col_end;
  } job_t;

  typedef struct packed {
    logic [POS_BITS-1:0] idx;
    logic [2:0]          wp;
  } tap_t;

  // Output position k completed on one axis by input position p, with the
  // quarter weight of the previous input.
  function automatic tap_t axis_tap(input logic [1:0] k, input logic [COL_BITS-1:0] p,
                                    input logic first, input logic [POS_BITS-1:0] pend);
    tap_t t;
    logic [POS_BITS-1:0] twice;
    twice = {p, 1'b0};
    t.idx = pend;
    t.wp  = 3'd0;
    if (first) begin
      if (k == 2'd0) begin
        t.idx = '0;
        t.wp  = 3'd0;
      end
    end else begin
      if (k == 2'd0) begin
        t.idx = twice - POS_BITS'(1);
        t.wp  = 3'd3;
      end else if (k == 2'd1) begin
        t.idx = twice;
        t.wp  = 3'd1;
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bu2x_emit.sv -----
// Pixel emitter: walks the output taps of one job and drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module bu2x_emit (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   job_valid_i,
  input  wire bu2x_pkg::job_t                   job_i,
  output logic                                  job_take_o,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [bu2x_pkg::SAMPLE_BITS-1:0] pixel_o,
  output logic [bu2x_pkg::POS_BITS-1:0]         out_row_o,
  output logic [bu2x_pkg::POS_BITS-1:0]         out_col_o,
  output logic                                  last_o
);

  bu2x_pkg::job_t job_q;
  logic           job_v_q;
  logic [1:0]     i_q, i_d;
  logic [1:0]     j_q, j_d;
  logic           out_v_q;
  logic signed [bu2x_pkg::SAMPLE_BITS-1:0] pixel_q, pixel_d;
  logic [bu2x_pkg::POS_BITS-1:0] row_q, col_q;
  logic           last_q;

  logic [1:0]     nr, nc;
  bu2x_pkg::tap_t rt, ct;
  logic           adv, row_done, col_done, done;
  logic signed [3:0] wrp, wrc, wcp, wcc;
  logic signed [bu2x_pkg::TOP_BITS-1:0] top, bot;
  logic signed [bu2x_pkg::SUM_BITS-1:0] sum, sum_r;

  always_comb begin
    nr = 2'd1 + {1'b0, ~job_q.row_first} + {1'b0, job_q.row_last};
    nc = 2'd1 + {1'b0, ~job_q.col_first} + {1'b0, job_q.col_last};
    rt = bu2x_pkg::axis_tap(i_q, bu2x_pkg::COL_BITS'(job_q.row), job_q.row_first,
                            job_q.row_end);
    ct = bu2x_pkg::axis_tap(j_q, job_q.col, job_q.col_first, job_q.col_end);
    wrp = $signed({1'b0, rt.wp});
    wrc = $signed({1'b0, 3'd4 - rt.wp});
    wcp = $signed({1'b0, ct.wp});
    wcc = $signed({1'b0, 3'd4 - ct.wp});
    top = bu2x_pkg::TOP_BITS'(wcp) * bu2x_pkg::TOP_BITS'(job_q.above_left)
        + bu2x_pkg::TOP_BITS'(wcc) * bu2x_pkg::TOP_BITS'(job_q.above);
    bot = bu2x_pkg::TOP_BITS'(wcp) * bu2x_pkg::TOP_BITS'(job_q.left)
        + bu2x_pkg::TOP_BITS'(wcc) * bu2x_pkg::TOP_BITS'(job_q.cur);
    sum = bu2x_pkg::SUM_BITS'(wrp) * bu2x_pkg::SUM_BITS'(top)
        + bu2x_pkg::SUM_BITS'(wrc) * bu2x_pkg::SUM_BITS'(bot);
    sum_r   = sum + bu2x_pkg::SUM_BITS'(8);
    pixel_d = bu2x_pkg::SAMPLE_BITS'(sum_r >>> 4);

    row_done = (i_q == nr - 2'd1);
    col_done = (j_q == nc - 2'd1);
    adv      = job_v_q && (!out_v_q || !out_stall_i);
    done     = adv && row_done && col_done;
    job_take_o = !job_v_q || done;

    i_d = i_q;
    j_d = j_q;
    if (col_done) begin
      j_d = 2'd0;
      i_d = i_q + 2'd1;
    end else begin
      j_d = j_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      i_q     <= 2'd0;
      j_q     <= 2'd0;
      out_v_q <= 1'b0;
    end else begin
      if (job_take_o && job_valid_i) begin
        job_v_q <= 1'b1;
        i_q     <= 2'd0;
        j_q     <= 2'd0;
      end else if (done) begin
        job_v_q <= 1'b0;
      end else if (adv) begin
        i_q <= i_d;
        j_q <= j_d;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o && job_valid_i) begin
      job_q <= job_i;
    end
    if (adv) begin
      pixel_q <= pixel_d;
      row_q   <= rt.idx;
      col_q   <= ct.idx;
      last_q  <= row_done && col_done;
    end
  end

  assign out_valid_o = out_v_q;
  assign pixel_o     = pixel_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/bilinear_upsample_2x_core.sv -----
// Top level of the 2x bilinear upsampler: config, raster counters, line store, job stage.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid_i/in_stall_o   | sample_i
//   output  | out       | out_valid_o/out_stall_i | pixel_o, out_row_o, out_col_o, last_o
//   config  | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A sample completes a number of output pixels set by its place: 1 for the first sample
// of a plane, 2 on the first row or column, 4 inside, up to 9 for the last one.
// The emitter's output register delivers one pixel per cycle unless out_stall_i holds it.
// The line store is a one-port synchronous RAM read and written on each input beat.
// Reset clears control state and the neighbor registers; the line store is not cleared.
// A stall on the output holds the output register; the input stalls once the job
// stage and the read stage are both full.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_upsample_2x_core (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_we_i,
  input  wire                                     cfg_idx_i,
  input  wire  [bu2x_pkg::SIZE_BITS-1:0]          cfg_data_i,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire  signed [bu2x_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic signed [bu2x_pkg::SAMPLE_BITS-1:0] pixel_o,
  output logic [bu2x_pkg::POS_BITS-1:0]           out_row_o,
  output logic [bu2x_pkg::POS_BITS-1:0]           out_col_o,
  output logic                                    last_o
);

  logic [bu2x_pkg::SIZE_BITS-1:0] width_q, height_q;
  logic [bu2x_pkg::SIZE_BITS-1:0] w_eff, h_eff;
  logic [bu2x_pkg::COL_BITS-1:0]  col_q, col_d;
  logic [bu2x_pkg::ROW_BITS-1:0]  row_q, row_d;
  logic signed [bu2x_pkg::SAMPLE_BITS-1:0] left_q, above_left_q;
  logic signed [bu2x_pkg::SAMPLE_BITS-1:0] line_mem [bu2x_pkg::MAX_WIDTH];
  logic signed [bu2x_pkg::SAMPLE_BITS-1:0] rd_q;

  bu2x_pkg::job_t s1_q, job;
  logic           s1_v_q;
  logic           take, accept;
  logic           col_wrap, row_wrap;

  always_comb begin
    if (width_q == '0) begin
      w_eff = bu2x_pkg::SIZE_BITS'(1);
    end else if (width_q > bu2x_pkg::SIZE_BITS'(bu2x_pkg::MAX_WIDTH)) begin
      w_eff = bu2x_pkg::SIZE_BITS'(bu2x_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = bu2x_pkg::SIZE_BITS'(1);
    end else if (height_q > bu2x_pkg::SIZE_BITS'(bu2x_pkg::MAX_HEIGHT)) begin
      h_eff = bu2x_pkg::SIZE_BITS'(bu2x_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end

    col_wrap = ({1'b0, col_q} + bu2x_pkg::SIZE_BITS'(1)) >= w_eff;
    row_wrap = ({1'b0, row_q} + bu2x_pkg::SIZE_BITS'(1)) >= h_eff;
    col_d = col_wrap ? '0 : col_q + bu2x_pkg::COL_BITS'(1);
    row_d = row_q;
    if (col_wrap) begin
      row_d = row_wrap ? '0 : row_q + bu2x_pkg::ROW_BITS'(1);
    end

    in_stall_o = s1_v_q && !take;
    accept     = in_valid_i && !in_stall_o;

    // The above sample arrives from the RAM in the cycle after the beat. On the first
    // row, and for the above-left sample on the first column, those samples carry zero
    // weight and may not have been written yet, so zero stands in for them.
    job            = s1_q;
    job.above      = s1_q.row_first ? '0 : rd_q;
    job.above_left = (s1_q.row_first || s1_q.col_first) ? '0 : above_left_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= bu2x_pkg::SIZE_BITS'(bu2x_pkg::MAX_WIDTH);
      height_q     <= bu2x_pkg::SIZE_BITS'(bu2x_pkg::MAX_HEIGHT);
      col_q        <= '0;
      row_q        <= '0;
      left_q       <= '0;
      above_left_q <= '0;
      s1_v_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bu2x_pkg::CFG_IN_WIDTH) begin
          width_q <= cfg_data_i;
        end
        if (cfg_idx_i == bu2x_pkg::CFG_IN_HEIGHT) begin
          height_q <= cfg_data_i;
        end
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept) begin
        left_q <= sample_i;
        s1_v_q <= 1'b1;
      end else if (take) begin
        s1_v_q <= 1'b0;
      end
      if (s1_v_q && take) begin
        above_left_q <= rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.cur       <= sample_i;
      s1_q.left      <= left_q;
      s1_q.row       <= row_q;
      s1_q.col       <= col_q;
      s1_q.row_first <= (row_q == '0);
      s1_q.row_last  <= ({1'b0, row_q} + bu2x_pkg::SIZE_BITS'(1)) == h_eff;
      s1_q.col_first <= (col_q == '0);
      s1_q.col_last  <= col_wrap;
      s1_q.row_end   <= bu2x_pkg::POS_BITS'({h_eff, 1'b0} - 12'd1);
      s1_q.col_end   <= bu2x_pkg::POS_BITS'({w_eff, 1'b0} - 12'd1);
      s1_q.above      <= '0;
      s1_q.above_left <= '0;
    end
  end

  // Line store: read the previous row's sample and overwrite it in the same beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q           <= line_mem[col_q];
      line_mem[col_q] <= sample_i;
    end
  end

  bu2x_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (s1_v_q),
    .job_i       (job),
    .job_take_o  (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_o     (pixel_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
